// File: hdl/dpr_pkg.sv
`default_nettype none

package dpr_pkg;

  localparam int BUFFER_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int LEN_W        = 10;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // framing characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;

  // result kinds on the output
  localparam logic [1:0] RK_GOOD     = 2'd0;
  localparam logic [1:0] RK_MISMATCH = 2'd1;
  localparam logic [1:0] RK_READ     = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RESULT,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       ack_char;
    logic             seq_present;
    logic [7:0]       seq_first;
    logic [7:0]       seq_second;
    logic [1:0]       payload_offset;
    logic [LEN_W-1:0] payload_length;
  } result_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              read_ok;
    result_t           res;
  } op_t;

endpackage

`default_nettype wire

// File: hdl/dpr_front.sv
`default_nettype none

module dpr_front
  import dpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [LEN_W-1:0] read_index,
  input  wire logic             queue_full,
  output logic                  push,
  output op_t                   push_op
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_PAYLOAD,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t            phase, phase_next;
  logic [7:0]        running_sum, running_sum_next;
  logic [7:0]        sent_high, sent_high_next;
  logic [ADDR_W-1:0] byte_count, byte_count_next;
  logic [ADDR_W-1:0] stored_length, stored_length_next;
  logic [7:0]        seq0, seq1, seq2;
  logic [ADDR_W-1:0] count_inc;
  logic [7:0]        digit;
  logic [7:0]        sent_sum;
  logic              accept;

  // hex digit value, anything else counts as minus one
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hff;
    if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v;
  endfunction

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign count_inc = byte_count + ADDR_W'(1);
  assign digit     = hex_value(rx_byte);
  assign sent_sum  = sent_high + digit;

  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    sent_high_next     = sent_high;
    byte_count_next    = byte_count;
    stored_length_next = stored_length;
    push               = 1'b0;
    push_op            = '0;
    push_op.kind       = OP_WRITE;

    if (accept) begin
      if (req_type) begin
        push                = 1'b1;
        push_op.kind        = OP_READ;
        push_op.addr        = ADDR_W'(read_index);
        push_op.read_ok     = read_index < LEN_W'(stored_length);
        push_op.res.result_kind = RK_READ;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (rx_byte == CH_DOLLAR) begin
              running_sum_next = '0;
              byte_count_next  = '0;
              phase_next       = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (rx_byte == CH_DOLLAR) begin
              running_sum_next = '0;
              byte_count_next  = '0;
            end else if (rx_byte == CH_HASH) begin
              stored_length_next = byte_count;
              phase_next         = PH_HIGH;
            end else begin
              running_sum_next = running_sum + rx_byte;
              push             = 1'b1;
              push_op.kind     = OP_WRITE;
              push_op.addr     = byte_count;
              push_op.data     = rx_byte;
              byte_count_next  = count_inc;
              // buffer full: drop silently and hunt again
              if (count_inc >= ADDR_W'(BUFFER_DEPTH - 1)) begin
                stored_length_next = count_inc;
                phase_next         = PH_HUNT;
              end
            end
          end
          PH_HIGH: begin
            sent_high_next = {digit[3:0], 4'h0};
            phase_next     = PH_LOW;
          end
          PH_LOW: begin
            phase_next   = PH_HUNT;
            push         = 1'b1;
            push_op.kind = OP_RESULT;
            if (sent_sum != running_sum) begin
              push_op.res.result_kind = RK_MISMATCH;
              push_op.res.ack_char    = CH_MINUS;
            end else begin
              push_op.res.result_kind    = RK_GOOD;
              push_op.res.ack_char       = CH_PLUS;
              push_op.res.payload_length = LEN_W'(stored_length);
              if (stored_length >= ADDR_W'(3) && seq2 == CH_COLON) begin
                push_op.res.seq_present    = 1'b1;
                push_op.res.seq_first      = seq0;
                push_op.res.seq_second     = seq1;
                push_op.res.payload_offset = 2'd3;
              end
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= '0;
      sent_high     <= '0;
      byte_count    <= '0;
      stored_length <= '0;
    end else begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      sent_high     <= sent_high_next;
      byte_count    <= byte_count_next;
      stored_length <= stored_length_next;
    end
    // shadow copies of the first three buffer bytes for the sequence id
    if (push && push_op.kind == OP_WRITE) begin
      if (push_op.addr == ADDR_W'(0)) seq0 <= push_op.data;
      if (push_op.addr == ADDR_W'(1)) seq1 <= push_op.data;
      if (push_op.addr == ADDR_W'(2)) seq2 <= push_op.data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/dpr_queue.sv
`default_nettype none

module dpr_queue
  import dpr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  op_t       push_op,
  output logic      full,
  output logic      head_valid,
  output op_t       head_op,
  input  wire logic pop
);

  op_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;

  assign full       = count == (FIFO_PTR_W+1)'(FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      if (push && !pop) count <= count + (FIFO_PTR_W+1)'(1);
      else if (pop && !push) count <= count - (FIFO_PTR_W+1)'(1);
    end
    if (push) slots[wr_ptr] <= push_op;
  end

endmodule

`default_nettype wire

// File: hdl/dpr_back.sv
`default_nettype none

module dpr_back
  import dpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  op_t            head_op,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output result_t        out_res,
  output logic [7:0]     out_read_data
);

  logic [7:0]  payload_mem [BUFFER_DEPTH];
  logic [7:0]  mem_q;
  logic        out_is_read;
  logic        out_read_ok;
  logic        slot_free;
  logic        take_result;

  assign slot_free   = !out_valid || !out_stall;
  assign pop         = head_valid && (head_op.kind == OP_WRITE || slot_free);
  assign take_result = pop && head_op.kind != OP_WRITE;

  assign out_read_data = (out_is_read && out_read_ok) ? mem_q : 8'h00;

  always_ff @(posedge clk) begin
    if (pop && head_op.kind == OP_WRITE) payload_mem[head_op.addr] <= head_op.data;
    if (pop && head_op.kind == OP_READ) mem_q <= payload_mem[head_op.addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (take_result) begin
      out_res     <= head_op.res;
      out_is_read <= head_op.kind == OP_READ;
      out_read_ok <= head_op.read_ok;
    end
  end

endmodule

`default_nettype wire

// File: hdl/debug_packet_receiver_top.sv
// debugger packet receiver: takes one link byte or one buffer read request per
// cycle while in_stall is low; the front end frames packets, keeps the running
// checksum and the byte count, and hands buffer writes, packet results and read
// requests in order to the back end through a four-entry queue, so input and
// output stall on their own until that queue fills; the back end owns the
// 1024-byte payload ram (one port used per cycle) and a single output register;
// with the queue empty and the output register free, a packet result goes from
// the second checksum digit through a queue slot into the output register, and a
// read request the same way, the registered ram read landing on the same edge that
// loads the output register; the ram is not cleared after reset and needs no sweep
`default_nettype none

module debug_packet_receiver_top
  import dpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             req_type,
  input  wire logic [7:0]       rx_byte,
  input  wire logic [LEN_W-1:0] read_index,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            result_kind,
  output logic [7:0]            ack_char,
  output logic                  seq_present,
  output logic [7:0]            seq_first,
  output logic [7:0]            seq_second,
  output logic [1:0]            payload_offset,
  output logic [LEN_W-1:0]      payload_length,
  output logic [7:0]            read_data
);

  logic    push;
  op_t     push_op;
  logic    queue_full;
  logic    head_valid;
  op_t     head_op;
  logic    pop;
  result_t out_res;

  // framing, checksum and buffer bookkeeping; one transfer per cycle while the queue is not full
  dpr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .rx_byte    (rx_byte),
    .read_index (read_index),
    .queue_full (queue_full),
    .push       (push),
    .push_op    (push_op)
  );

  // keeps writes, results and reads in arrival order
  dpr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  // payload ram and output register; writes drain even while output is held
  dpr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .out_read_data (read_data)
  );

  assign result_kind    = out_res.result_kind;
  assign ack_char       = out_res.ack_char;
  assign seq_present    = out_res.seq_present;
  assign seq_first      = out_res.seq_first;
  assign seq_second     = out_res.seq_second;
  assign payload_offset = out_res.payload_offset;
  assign payload_length = out_res.payload_length;

endmodule

`default_nettype wire
